FILE: rtl/core/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants of the packet alignment search block.
// ----------------------------------------------------------------------------
package psa_pkg;

    // Search counters cover two packets plus one step
    localparam int IDX_W = 13;

    // Register indexes
    localparam logic [2:0] REG_REF_SAMPLES   = 3'd0;
    localparam logic [2:0] REG_REF_DATA_TYPE = 3'd1;
    localparam logic [2:0] REG_REF_CHANNELS  = 3'd2;
    localparam logic [2:0] REG_REF_RATE      = 3'd3;
    localparam logic [2:0] REG_FRAME_BYTES   = 3'd4;
    localparam logic [2:0] REG_PACKET_BYTES  = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_MISMATCH = 2'd0;
    localparam logic [1:0] ST_NO_PREV  = 2'd1;
    localparam logic [1:0] ST_DONE     = 2'd2;

    // Item kinds
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [8:0]  cand_samples;
        logic [2:0]  cand_data_type;
        logic [8:0]  cand_channels;
        logic [19:0] cand_rate;
        logic        cand_has_prev;
        logic [31:0] ref_counter;
        logic [31:0] cand_counter;
        logic [7:0]  ref_byte;
        logic [7:0]  prev_byte;
        logic [7:0]  curr_byte;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [11:0]        match_count;
        logic signed [47:0] sample_offset;
    } t_out_item;

    typedef struct packed {
        logic [8:0]  ref_samples;
        logic [2:0]  ref_data_type;
        logic [8:0]  ref_channels;
        logic [19:0] ref_rate;
        logic [11:0] frame_bytes;
        logic [11:0] packet_bytes;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_OFFS,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load_start;
        logic       load_data;
        logic       clr_search;
        logic       start_off;
        logic       adv_k;
        logic       match;
        logic       next_off;
        logic       set_code;
        logic [1:0] code;
        logic       out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic item_func;
        logic item_last;
        logic fits;
        logic hdr_match;
        logic prev_present;
        logic off_done;
        logic eq;
        logic k_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/core/psa_ram.sv
// ----------------------------------------------------------------------------
// psa_ram
// Generic RAM with two write ports and one registered read port.
// ----------------------------------------------------------------------------
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_we_b,
    input  logic [$clog2(DEPTH)-1:0] i_waddr_b,
    input  logic [WIDTH-1:0]         i_wdata_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write both ports and register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we_b) begin
            r_mem[i_waddr_b] <= i_wdata_b;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/psa_regs.sv
// ----------------------------------------------------------------------------
// psa_regs
// APB configuration registers for the reference stream format.
// ----------------------------------------------------------------------------
module psa_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output psa_pkg::t_cfg     o_cfg
);
    import psa_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_samples   <= 9'd256;
            r_cfg.ref_data_type <= 3'd0;
            r_cfg.ref_channels  <= 9'd2;
            r_cfg.ref_rate      <= 20'd48000;
            r_cfg.frame_bytes   <= 12'd4;
            r_cfg.packet_bytes  <= 12'd1024;
        end else if (w_wr) begin
            case (w_idx)
                REG_REF_SAMPLES:   r_cfg.ref_samples   <= pwdata[8:0];
                REG_REF_DATA_TYPE: r_cfg.ref_data_type <= pwdata[2:0];
                REG_REF_CHANNELS:  r_cfg.ref_channels  <= pwdata[8:0];
                REG_REF_RATE:      r_cfg.ref_rate      <= pwdata[19:0];
                REG_FRAME_BYTES:   r_cfg.frame_bytes   <= pwdata[11:0];
                REG_PACKET_BYTES:  r_cfg.packet_bytes  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_idx)
            REG_REF_SAMPLES:   prdata = {23'd0, r_cfg.ref_samples};
            REG_REF_DATA_TYPE: prdata = {29'd0, r_cfg.ref_data_type};
            REG_REF_CHANNELS:  prdata = {23'd0, r_cfg.ref_channels};
            REG_REF_RATE:      prdata = {12'd0, r_cfg.ref_rate};
            REG_FRAME_BYTES:   prdata = {20'd0, r_cfg.frame_bytes};
            REG_PACKET_BYTES:  prdata = {20'd0, r_cfg.packet_bytes};
            default:           prdata = 32'd0;
        endcase
    end
endmodule

FILE: rtl/core/psa_ctrl.sv
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer for loading, the offset-by-offset compare and result hand-off.
// ----------------------------------------------------------------------------
module psa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  psa_pkg::t_dp_stat     i_stat,
    output psa_pkg::t_ctrl_cmd    o_cmd
);
    import psa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_stat.item_func == FUNC_DATA && i_stat.item_last &&
                    i_stat.fits) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.hdr_match || !i_stat.prev_present) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_OFFS;
                end
            end
            S_OFFS: begin
                n_state = i_stat.off_done ? S_DONE : S_READ;
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (!i_stat.eq || i_stat.k_last) begin
                    n_state = S_OFFS;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_start = w_acc && i_stat.item_func == FUNC_START;
                o_cmd.load_data  = w_acc && i_stat.item_func == FUNC_DATA;
            end
            S_CHECK: begin
                o_cmd.clr_search = 1'b1;
                o_cmd.set_code   = 1'b1;
                if (!i_stat.hdr_match) begin
                    o_cmd.code = ST_MISMATCH;
                end else if (!i_stat.prev_present) begin
                    o_cmd.code = ST_NO_PREV;
                end else begin
                    o_cmd.code = ST_DONE;
                end
            end
            S_OFFS: begin
                o_cmd.start_off = 1'b1;
            end
            S_READ: ;
            S_CMP: begin
                if (!i_stat.eq) begin
                    o_cmd.next_off = 1'b1;
                end else if (i_stat.k_last) begin
                    o_cmd.match    = 1'b1;
                    o_cmd.next_off = 1'b1;
                end else begin
                    o_cmd.adv_k = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: ;
        endcase
    end
endmodule

FILE: rtl/core/psa_dp.sv
// ----------------------------------------------------------------------------
// psa_dp
// Datapath: packet stores, search counters, offset arithmetic, result stage.
// ----------------------------------------------------------------------------
module psa_dp #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  psa_pkg::t_cfg         i_cfg,
    input  psa_pkg::t_in_item     i_item,
    input  psa_pkg::t_ctrl_cmd    i_cmd,
    output psa_pkg::t_dp_stat     o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output psa_pkg::t_out_item    o_out_data
);
    import psa_pkg::*;

    localparam int AW  = $clog2(MAX_PACKET_BYTES);
    localparam int WAW = $clog2(2 * MAX_PACKET_BYTES);

    // Format and counter state from the start transaction
    logic               r_hdr;
    logic               r_prev;
    logic signed [33:0] r_delta;
    logic [11:0]        r_wi;
    logic signed [47:0] r_base;

    // Search state
    logic [IDX_W-1:0]   r_i;
    logic [IDX_W-1:0]   r_k;
    logic [IDX_W-1:0]   r_fidx;
    logic [11:0]        r_count;
    logic signed [47:0] r_offset;
    logic [1:0]         r_code;

    // Result stage
    logic               r_out_valid;
    t_out_item          r_out;

    logic [IDX_W-1:0]   w_pb;
    logic [IDX_W-1:0]   w_step;
    logic [IDX_W-1:0]   w_w;
    logic [IDX_W-1:0]   w_wa_prev;
    logic [IDX_W-1:0]   w_wa_curr;
    logic               w_fits;
    logic               w_wr;
    logic               w_hdr;
    logic signed [43:0] w_prod;
    logic [7:0]         w_ref_rd;
    logic [7:0]         w_win_rd;

    assign w_pb      = {1'b0, i_cfg.packet_bytes};
    assign w_step    = (i_cfg.frame_bytes == 12'd0) ? IDX_W'(1) : {1'b0, i_cfg.frame_bytes};
    assign w_fits    = w_pb <= IDX_W'(MAX_PACKET_BYTES);
    assign w_wr      = i_cmd.load_data && w_fits && ({1'b0, r_wi} < w_pb);
    assign w_w       = r_i + r_k;
    assign w_wa_prev = {1'b0, r_wi};
    assign w_wa_curr = w_pb + {1'b0, r_wi};
    assign w_hdr     = i_item.cand_samples == i_cfg.ref_samples &&
                       i_item.cand_data_type == i_cfg.ref_data_type &&
                       i_item.cand_channels == i_cfg.ref_channels &&
                       i_item.cand_rate == i_cfg.ref_rate;
    assign w_prod    = r_delta * $signed({1'b0, i_cfg.ref_samples});

    // Reference packet
    psa_ram #(.WIDTH(8), .DEPTH(MAX_PACKET_BYTES)) u_ref_ram (
        .i_clk     (i_clk),
        .i_we      (w_wr),
        .i_waddr   (r_wi[AW-1:0]),
        .i_wdata   (i_item.ref_byte),
        .i_we_b    (1'b0),
        .i_waddr_b ('0),
        .i_wdata_b (8'd0),
        .i_raddr   (r_k[AW-1:0]),
        .o_rdata   (w_ref_rd)
    );

    // Two-packet window: previous packet below packet_bytes, current above
    psa_ram #(.WIDTH(8), .DEPTH(2 * MAX_PACKET_BYTES)) u_win_ram (
        .i_clk     (i_clk),
        .i_we      (w_wr),
        .i_waddr   (w_wa_prev[WAW-1:0]),
        .i_wdata   (i_item.prev_byte),
        .i_we_b    (w_wr),
        .i_waddr_b (w_wa_curr[WAW-1:0]),
        .i_wdata_b (i_item.curr_byte),
        .i_raddr   (w_w[WAW-1:0]),
        .o_rdata   (w_win_rd)
    );

    // Start and data transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= 1'b0;
            r_prev  <= 1'b0;
            r_delta <= '0;
            r_wi    <= '0;
        end else if (i_cmd.load_start) begin
            r_hdr   <= w_hdr;
            r_prev  <= i_item.cand_has_prev;
            r_delta <= $signed({2'b00, i_item.cand_counter} - 34'd1 -
                               {2'b00, i_item.ref_counter});
            r_wi    <= '0;
        end else if (i_cmd.load_data) begin
            if (i_item.last) begin
                r_wi <= '0;
            end else if (r_wi != 12'hFFF) begin
                r_wi <= r_wi + 12'd1;
            end
        end
    end

    // Base offset from the packet counter difference
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_data) begin
            r_base <= 48'(w_prod);
        end
    end

    // Search counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_search) begin
            r_i      <= '0;
            r_k      <= '0;
            r_fidx   <= '0;
            r_count  <= '0;
            r_offset <= '0;
        end else begin
            if (i_cmd.start_off) begin
                r_k <= '0;
            end
            if (i_cmd.adv_k) begin
                r_k <= r_k + IDX_W'(1);
            end
            if (i_cmd.match) begin
                if (r_count == 12'd0) begin
                    r_offset <= r_base + $signed({35'd0, r_fidx});
                end
                if (r_count != 12'hFFF) begin
                    r_count <= r_count + 12'd1;
                end
            end
            if (i_cmd.next_off) begin
                r_i    <= r_i + w_step;
                r_fidx <= r_fidx + IDX_W'(1);
            end
        end
        if (i_cmd.set_code) begin
            r_code <= i_cmd.code;
        end
    end

    // Result register, held until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status        <= r_code;
            r_out.match_count   <= r_count;
            r_out.sample_offset <= r_offset;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status toward the sequencer
    assign o_stat.item_func    = i_item.func;
    assign o_stat.item_last    = i_item.last;
    assign o_stat.fits         = w_fits;
    assign o_stat.hdr_match    = r_hdr;
    assign o_stat.prev_present = r_prev;
    assign o_stat.off_done     = r_i >= w_pb;
    assign o_stat.eq           = w_win_rd == w_ref_rd;
    assign o_stat.k_last       = (r_k + IDX_W'(1)) == w_pb;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;
endmodule

FILE: rtl/core/packet_alignment_search.sv
// ----------------------------------------------------------------------------
// packet_alignment_search
// Locates the latest reference packet inside the candidate's last two packets.
// ----------------------------------------------------------------------------
// Usage: program the reference format, frame size and packet size over APB
// while idle. Send a start transaction (func 0) with the candidate header and
// both counters, then one data transaction per payload byte (func 1), last
// flagged on the final byte. Start and non-final data transactions leave the
// block ready for the next one. The final byte produces one result: status,
// match count and the sample offset of the first match. Format mismatch or a
// missing previous packet skips the search: the sequencer goes from its check
// state to its done state. The search reads each byte pair through the packet
// stores' registered read port, compares it in the compare state and leaves
// an offset at its first mismatch. Packets longer than MAX_PACKET_BYTES give
// no result. The result waits in an output register when the receiver stalls;
// no new input is taken until it is loaded there. Reset clears control state;
// the packet stores hold no reset value.
// ----------------------------------------------------------------------------
module packet_alignment_search #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  psa_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output psa_pkg::t_out_item    o_out_data
);
    import psa_pkg::*;

    t_cfg      w_cfg;
    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    // Configuration registers
    psa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer
    psa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath
    psa_dp #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_item      (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A result with no match carries a zero offset
    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.match_count == 12'd0 |->
        o_out_data.sample_offset == 48'sd0)
        else $error("offset set without a match");

    // Error statuses carry no matches
    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_DONE |->
        o_out_data.match_count == 12'd0)
        else $error("matches reported with error status");

    // A final byte of a fitting packet starts the search and blocks input
    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.func == FUNC_DATA &&
        i_in_data.last && w_stat.fits |=> !o_in_ready)
        else $error("input taken during search");
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives start and byte transactions into the packet alignment search block,
// predicts each result from a local copy of the packet stores and header
// state, and checks status, match count and sample offset of every result.
// ----------------------------------------------------------------------------
module testbench;
    import psa_pkg::*;

    localparam int MAXP = 2048;
    localparam int IN_W = $bits(t_in_item);

    // Predicts search results and holds the results still owed by the block
    class align_scoreboard;
        t_cfg        cfg;
        logic [7:0]  ref_st [MAXP];
        logic [7:0]  win_st [2*MAXP];
        bit          ref_wr [MAXP];
        bit          win_wr [2*MAXP];
        bit          hdr_ok;
        bit          prev_ok;
        longint      delta;
        int          widx;
        t_out_item   owed[$];
        int          errors;
        int          n_items;
        int          n_results;
        int          n_found;

        function new();
            cfg = '{ref_samples: 9'd256, ref_data_type: 3'd0, ref_channels: 9'd2,
                    ref_rate: 20'd48000, frame_bytes: 12'd4, packet_bytes: 12'd1024};
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_REF_SAMPLES:   cfg.ref_samples   = v[8:0];
                REG_REF_DATA_TYPE: cfg.ref_data_type = v[2:0];
                REG_REF_CHANNELS:  cfg.ref_channels  = v[8:0];
                REG_REF_RATE:      cfg.ref_rate      = v[19:0];
                REG_FRAME_BYTES:   cfg.frame_bytes   = v[11:0];
                REG_PACKET_BYTES:  cfg.packet_bytes  = v[11:0];
                default: ;
            endcase
        endfunction

        // Slide the reference packet across the window one frame at a time
        function t_out_item search();
            t_out_item r;
            int size, step, cnt;
            bit eq;
            longint off;
            size = cfg.packet_bytes;
            step = (cfg.frame_bytes == 0) ? 1 : cfg.frame_bytes;
            cnt = 0;
            off = 0;
            for (int i = 0; i < size; i += step) begin
                eq = 1;
                for (int j = 0; j < size && eq; j++)
                    if (ref_st[j] != win_st[i+j]) eq = 0;
                if (eq) begin
                    if (cnt == 0) off = delta * longint'(cfg.ref_samples) + i / step;
                    if (cnt < 4095) cnt++;
                end
            end
            r.status = ST_DONE;
            r.match_count = cnt[11:0];
            r.sample_offset = off[47:0];
            return r;
        endfunction

        function void note_input(t_in_item it);
            bit fits;
            n_items++;
            if (it.func == FUNC_START) begin
                hdr_ok = it.cand_samples == cfg.ref_samples &&
                         it.cand_data_type == cfg.ref_data_type &&
                         it.cand_channels == cfg.ref_channels &&
                         it.cand_rate == cfg.ref_rate;
                prev_ok = it.cand_has_prev;
                delta = longint'(it.cand_counter) - 1 - longint'(it.ref_counter);
                widx = 0;
                return;
            end
            fits = cfg.packet_bytes <= MAXP;
            if (fits && widx < cfg.packet_bytes) begin
                ref_st[widx] = it.ref_byte;
                win_st[widx] = it.prev_byte;
                win_st[cfg.packet_bytes + widx] = it.curr_byte;
                ref_wr[widx] = 1;
                win_wr[widx] = 1;
                win_wr[cfg.packet_bytes + widx] = 1;
            end
            if (widx < 4095) widx++;
            if (!it.last) return;
            widx = 0;
            if (!fits) return;
            if (!hdr_ok)       owed.push_back('{ST_MISMATCH, 12'd0, 48'sd0});
            else if (!prev_ok) owed.push_back('{ST_NO_PREV, 12'd0, 48'sd0});
            else               owed.push_back(search());
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("ERROR %0t: %s", $time, msg);
        endfunction

        function void check(t_out_item got);
            t_out_item exp;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            exp = owed.pop_front();
            n_results++;
            if (exp.match_count != 0) n_found++;
            if (got.status != exp.status || got.match_count != exp.match_count ||
                got.sample_offset != exp.sample_offset)
                report($sformatf("expected %p got %p", exp, got));
        endfunction

        // True when a search after a short packet reads only written entries
        function bit covered(int len);
            int pb;
            pb = cfg.packet_bytes;
            for (int j = 0; j < pb; j++)
                if (!ref_wr[j] && j >= len) return 0;
            for (int x = 0; x < 2*pb - 1; x++)
                if (!win_wr[x] && x >= len && !(x >= pb && x - pb < len)) return 0;
            return 1;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        in_valid, in_ready, out_valid, out_ready;
    t_in_item    in_data;
    t_out_item   out_data;

    align_scoreboard sb;
    int  burst_left;
    bit  hold_req;

    packet_alignment_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    always #5 i_clk = ~i_clk;

    // Write one register with an APB setup phase and an access phase
    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = v;
        @(negedge i_clk);
        penable = 1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic configure(int rs, int dt, int ch, int rate, int fb, int pb);
        apb_write(REG_REF_SAMPLES, rs);
        apb_write(REG_REF_DATA_TYPE, dt);
        apb_write(REG_REF_CHANNELS, ch);
        apb_write(REG_REF_RATE, rate);
        apb_write(REG_FRAME_BYTES, fb);
        apb_write(REG_PACKET_BYTES, pb);
    endtask

    // Hold the sender until every owed result has come back
    task automatic drain();
        in_valid = 0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Offer one transaction in bursts with random gaps; called at a falling edge
    task automatic send_item(t_in_item it);
        if (burst_left == 0) begin
            in_valid = 0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
        end
        in_valid = 1;
        in_data = it;
        do @(posedge i_clk); while (!in_ready);
        sb.note_input(it);
        burst_left--;
        @(negedge i_clk);
    endtask

    // content: 0 random bytes, 1 reference cut from the window, 2 constant bytes
    task automatic send_packet(bit with_start, bit fmt_ok, bit has_prev, int len,
                               int content, longint rc = -1, longint kc = -1);
        t_in_item it;
        logic [7:0] w[], r[];
        logic [7:0] c;
        int pb, step, nof, s, f;
        pb = sb.cfg.packet_bytes;
        step = (sb.cfg.frame_bytes == 0) ? 1 : sb.cfg.frame_bytes;
        if (with_start) begin
            it = t_in_item'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            it.func = FUNC_START;
            it.cand_samples = sb.cfg.ref_samples;
            it.cand_data_type = sb.cfg.ref_data_type;
            it.cand_channels = sb.cfg.ref_channels;
            it.cand_rate = sb.cfg.ref_rate;
            if (!fmt_ok) begin
                f = $urandom_range(0, 3);
                case (f)
                    0: it.cand_samples ^= 9'($urandom_range(1, 511));
                    1: it.cand_data_type ^= 3'($urandom_range(1, 7));
                    2: it.cand_channels ^= 9'($urandom_range(1, 511));
                    default: it.cand_rate ^= 20'($urandom_range(1, 20'hFFFFF));
                endcase
            end
            it.cand_has_prev = has_prev;
            it.ref_counter = (rc != -1 || $urandom_range(0, 9) != 0) ? $urandom : '1;
            it.cand_counter = (kc != -1 || $urandom_range(0, 9) != 0) ? $urandom : '0;
            if (rc != -1) it.ref_counter = 32'(rc);
            if (kc != -1) it.cand_counter = 32'(kc);
            send_item(it);
        end
        if (pb <= MAXP) begin
            w = new[2*pb];
            r = new[pb];
            c = 8'($urandom);
            foreach (w[x]) w[x] = (content == 2) ? c : 8'($urandom);
            nof = (pb + step - 1) / step;
            s = (content == 1 && nof > 0) ? $urandom_range(0, nof - 1) * step : 0;
            foreach (r[j]) r[j] = (content == 1) ? w[s+j] : (content == 2 ? c : 8'($urandom));
            if (len < pb && !sb.covered(len)) len = pb;
        end
        for (int k = 0; k < len; k++) begin
            it = t_in_item'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            it.func = FUNC_DATA;
            if (k < pb && pb <= MAXP) begin
                it.ref_byte = r[k];
                it.prev_byte = w[k];
                it.curr_byte = w[pb+k];
            end
            it.last = (k == len - 1);
            send_item(it);
        end
    endtask

    // Receiver: switch between random stall patterns, with one long hold-off
    initial begin
        int mode;
        out_ready = 0;
        forever begin
            mode = $urandom_range(0, 2);
            for (int n = 0; n < 64; n++) begin
                @(negedge i_clk);
                if (hold_req) begin
                    out_ready = 0;
                    repeat (400) @(negedge i_clk);
                    hold_req = 0;
                end
                case (mode)
                    0: out_ready = 1;
                    1: out_ready = $urandom_range(0, 1);
                    default: out_ready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Check every result at the edge where it is taken
    always @(posedge i_clk)
        if (i_rst_n && out_valid && out_ready) sb.check(out_data);

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int pb, fb, len, ph;
        sb = new();
        i_clk = 0; i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; in_data = '0; burst_left = 0; hold_req = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: each status, match counts, counter extremes, missing start
        configure(256, 7, 1, 20'hFFFFF, 1, 4);
        send_packet(1, 0, 1, 4, 2);
        send_packet(1, 1, 0, 4, 2);
        send_packet(1, 1, 1, 4, 2, 32'hFFFF_FFFF, 0);
        send_packet(1, 1, 1, 4, 1, 0, 32'hFFFF_FFFF);
        send_packet(1, 1, 1, 4, 0);
        send_packet(0, 1, 1, 4, 1);
        drain();
        // Zero packet size and zero frame step
        configure(0, 0, 256, 0, 0, 0);
        send_packet(1, 1, 1, 1, 0);
        drain();
        apb_write(REG_PACKET_BYTES, 3);
        send_packet(1, 1, 1, 3, 2);
        send_packet(1, 1, 1, 3, 1);
        drain();
        // Oversized packet gives no result
        apb_write(REG_PACKET_BYTES, 4095);
        send_packet(1, 1, 1, 3, 0);
        drain();
        // Long packet with a coarse step
        configure(511, 3, 511, 12345, 128, 512);
        send_packet(1, 1, 1, 512, 1);
        drain();
        // Excess bytes past the packet end
        configure(48, 1, 2, 44100, 4095, 4);
        send_packet(1, 1, 1, 12, 0);
        send_packet(1, 1, 1, 4, 1);
        drain();

        // Random phases with fresh settings
        ph = 0;
        while (sb.n_items < 1100) begin
            pb = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            fb = ($urandom_range(0, 7) == 0) ? $urandom_range(pb, 4095) : $urandom_range(1, pb);
            configure($urandom_range(0, 511), $urandom_range(0, 7), $urandom_range(0, 511),
                      $urandom_range(0, 20'hFFFFF), fb, pb);
            if (ph == 0) hold_req = 1;
            repeat (14) begin
                case ($urandom_range(0, 19))
                    0, 1, 2:  len = pb + $urandom_range(1, 5);
                    3, 4:     len = $urandom_range(1, pb);
                    default:  len = pb;
                endcase
                send_packet($urandom_range(0, 6) != 0, $urandom_range(0, 4) != 0,
                            $urandom_range(0, 6) != 0, len, $urandom_range(0, 2));
            end
            drain();
            ph++;
        end
        repeat (50) @(negedge i_clk);

        $display("Covered %0d transactions, %0d results (%0d with matches), %0d phases.",
                 sb.n_items, sb.n_results, sb.n_found, ph);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.errors, sb.owed.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
